// ----- design/ppat_pkg.sv -----
// Shared types, field widths, codes and reset values for the peer presence aging table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ppat_pkg;

    localparam int TABLE_DEPTH_DEF = 12;

    // input word layout
    localparam int PEER_W     = 8;
    localparam int TIME_W     = 32;
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 1;

    // result word layout
    localparam int HB_W       = 2;
    localparam int COUNT_W    = 7;
    localparam int OUT_USED_W = HB_W + COUNT_W + 1 + COUNT_W;
    localparam int M_TDATA_W  = 24;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_MIN_SEEN = 2'd2;

    localparam logic [TIME_W-1:0]  EXPIRE_TIMEOUT_RST = 32'd15000;
    localparam logic [TIME_W-1:0]  GROUP_WINDOW_RST   = 32'd10000;
    localparam logic [COUNT_W-1:0] GROUP_MIN_SEEN_RST = 7'd2;

    // heartbeat status codes
    localparam logic [HB_W-1:0] ST_REFRESHED = 2'd0;
    localparam logic [HB_W-1:0] ST_INSERTED  = 2'd1;
    localparam logic [HB_W-1:0] ST_DROPPED   = 2'd2;
    localparam logic [HB_W-1:0] ST_NONE      = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan;
        logic commit;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- design/ppat_ctrl.sv -----
// Sequencer for the peer presence aging table: accept, scan, commit, deliver.
// Depends on ppat_pkg for the command and status structs.
`timescale 1ns / 1ps

module ppat_ctrl
    import ppat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.scan     = 1'b0;
        cmd.commit   = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/ppat_datapath.sv -----
// Datapath of the peer presence aging table: entry memory, valid bits, scan pipeline,
// configuration registers and result register. Depends on ppat_pkg.
`timescale 1ns / 1ps

module ppat_datapath
    import ppat_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_DEPTH);

    // entry memory; a slot whose valid bit is low reads as free
    logic [PEER_W-1:0] id_mem   [0:TABLE_DEPTH-1];
    logic [TIME_W-1:0] seen_mem [0:TABLE_DEPTH-1];
    logic [TABLE_DEPTH-1:0] valid_reg;

    logic [TIME_W-1:0]  expire_reg;
    logic [TIME_W-1:0]  window_reg;
    logic [COUNT_W-1:0] min_seen_reg;

    logic              tick_reg;
    logic [PEER_W-1:0] peer_reg;
    logic [TIME_W-1:0] now_reg;

    logic [CNT_W-1:0]  cnt_reg;
    logic              eval_pend_reg;
    logic [IDX_W-1:0]  eval_idx_reg;
    logic [PEER_W-1:0] rd_id_reg;
    logic [TIME_W-1:0] rd_seen_reg;

    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [CNT_W-1:0] seen_cnt_reg;
    logic [CNT_W-1:0] exp_cnt_reg;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic              rd_issue;
    logic [IDX_W-1:0]  rd_addr;
    logic [TIME_W-1:0] age;
    logic              entry_live;
    logic              age_over;
    logic              eval_hit;
    logic              eval_free;
    logic              eval_expire;
    logic              eval_seen;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [HB_W-1:0]   hb_status;
    logic [COUNT_W-1:0] seen_out;
    logic [COUNT_W-1:0] exp_out;
    logic              group_present;

    assign rd_issue = cmd.scan && (cnt_reg != LAST_CNT);
    assign rd_addr  = cnt_reg[IDX_W-1:0];

    assign age        = now_reg - rd_seen_reg;
    assign entry_live = valid_reg[eval_idx_reg];
    assign age_over   = (age > expire_reg);

    assign eval_hit    = eval_pend_reg && !tick_reg && entry_live && (rd_id_reg == peer_reg);
    assign eval_free   = eval_pend_reg && !tick_reg && !entry_live;
    assign eval_expire = eval_pend_reg && tick_reg && entry_live && age_over;
    assign eval_seen   = eval_pend_reg && tick_reg && entry_live && !age_over
                         && (age <= window_reg);

    assign wr_en  = cmd.commit && !tick_reg && (peer_reg != '0)
                    && (match_found_reg || free_found_reg);
    assign wr_idx = match_found_reg ? match_idx_reg : free_idx_reg;

    assign seen_out      = tick_reg ? COUNT_W'(seen_cnt_reg) : '0;
    assign exp_out       = tick_reg ? COUNT_W'(exp_cnt_reg) : '0;
    assign group_present = tick_reg && (seen_out >= min_seen_reg);

    always_comb
    begin
        priority if (tick_reg || (peer_reg == '0))
        begin
            hb_status = ST_NONE;
        end
        else if (match_found_reg)
        begin
            hb_status = ST_REFRESHED;
        end
        else if (free_found_reg)
        begin
            hb_status = ST_INSERTED;
        end
        else
        begin
            hb_status = ST_DROPPED;
        end
    end

    assign status.scan_done = (cnt_reg == LAST_CNT) && !eval_pend_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[wr_idx]   <= peer_reg;
            seen_mem[wr_idx] <= now_reg;
        end
        if (rd_issue)
        begin
            rd_id_reg   <= id_mem[rd_addr];
            rd_seen_reg <= seen_mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tick_reg <= s_tuser[0];
            peer_reg <= s_tdata[PEER_W-1:0];
            now_reg  <= s_tdata[PEER_W +: TIME_W];
        end
        eval_idx_reg <= rd_addr;
        if (eval_hit && !match_found_reg)
        begin
            match_idx_reg <= eval_idx_reg;
        end
        if (eval_free && !free_found_reg)
        begin
            free_idx_reg <= eval_idx_reg;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {{(M_TDATA_W - OUT_USED_W){1'b0}},
                             exp_out, group_present, seen_out, hb_status};
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            expire_reg      <= EXPIRE_TIMEOUT_RST;
            window_reg      <= GROUP_WINDOW_RST;
            min_seen_reg    <= GROUP_MIN_SEEN_RST;
            cnt_reg         <= '0;
            eval_pend_reg   <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            seen_cnt_reg    <= '0;
            exp_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_EXPIRE_TIMEOUT: expire_reg   <= cfg_data;
                    CFG_GROUP_WINDOW:   window_reg   <= cfg_data;
                    CFG_GROUP_MIN_SEEN: min_seen_reg <= cfg_data[COUNT_W-1:0];
                    default:            ;
                endcase
            end

            if (cmd.capture)
            begin
                cnt_reg         <= '0;
                eval_pend_reg   <= 1'b0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                seen_cnt_reg    <= '0;
                exp_cnt_reg     <= '0;
            end
            else
            begin
                eval_pend_reg <= rd_issue;
                if (rd_issue)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (eval_hit)
                begin
                    match_found_reg <= 1'b1;
                end
                if (eval_free)
                begin
                    free_found_reg <= 1'b1;
                end
                if (eval_expire)
                begin
                    exp_cnt_reg <= exp_cnt_reg + 1'b1;
                end
                if (eval_seen)
                begin
                    seen_cnt_reg <= seen_cnt_reg + 1'b1;
                end
            end

            // drop aged entries during a tick scan, claim a slot at heartbeat commit
            if (eval_expire)
            begin
                valid_reg[eval_idx_reg] <= 1'b0;
            end
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- design/peer_presence_aging_table.sv -----
// Peer presence aging table: each input word walks the entry memory read port one entry
// per cycle, then commits and loads the result word. A new input word is not taken until
// the previous one has been through the scan, commit and result hand-off states.
// The next input word is taken while a finished result still waits on the master side.
// Reset (rst_n, asynchronous, active low) marks every entry free through its valid bit
// and loads the configuration defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module peer_presence_aging_table
    import ppat_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input word
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] peer_id, [39:8] now_ms
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [0] command: 0 heartbeat, 1 tick
    // result word
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [1:0] hb_status, [8:2] seen_count,
                                             // [9] group_present, [16:10] expired_count,
                                             // [23:17] zero
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index, // 0 timeout, 1 window, 2 minimum seen
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // registers accept a write in any cycle
    assign cfg_ready = 1'b1;

    // controller: idle, scan the table, commit the heartbeat, hand off the result
    ppat_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: entry memory, valid bits, age compares, counters and result register
    ppat_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for peer_presence_aging_table: directed and random heartbeats and ticks.
// Predicts each result word from a local mirror of the peer table and the registers.
// Depends on ppat_pkg and the peer_presence_aging_table RTL only.
`timescale 1ns / 1ps

module tb;

    import ppat_pkg::*;

    localparam int DEPTH         = TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = DEPTH + 12;
    localparam int MAX_PRINTED   = 40;

    // input word kinds carried on s_tuser
    localparam logic CMD_HEARTBEAT = 1'b0;
    localparam logic CMD_TICK      = 1'b1;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic [HB_W-1:0]    hb_status;
        logic [COUNT_W-1:0] seen_count;
        logic               group_present;
        logic [COUNT_W-1:0] expired_count;
    } presence_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] peer_id, [39:8] now_ms
    logic [S_TUSER_W-1:0]  s_tuser   = '0;   // [0] command
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [1:0] hb_status, [8:2] seen_count,
                                             // [9] group_present, [16:10] expired_count
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // mirror of the block's table and registers
    logic [PEER_W-1:0]  peer_tab [DEPTH];
    logic [TIME_W-1:0]  heard_at [DEPTH];
    logic [TIME_W-1:0]  timeout_cfg  = EXPIRE_TIMEOUT_RST;
    logic [TIME_W-1:0]  window_cfg   = GROUP_WINDOW_RST;
    logic [COUNT_W-1:0] min_seen_cfg = GROUP_MIN_SEEN_RST;

    presence_result_t pending_results [$];

    int error_count = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    peer_presence_aging_table #(.TABLE_DEPTH(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Stop a hung run: the slowest correct run stays far below this count.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stall the result side at the rate of the current phase.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    // Print one line per mismatch (up to a cap) and count every one.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTED)
            $display("MISMATCH %s: got %0d expected %0d at cycle %0d",
                     what, got, want, cycle_count);
        error_count++;
    endtask

    // Advance the table mirror by one input word and return the result word it causes.
    function automatic presence_result_t predict_presence(input logic cmd,
                                                          input logic [PEER_W-1:0] id,
                                                          input logic [TIME_W-1:0] now);
        presence_result_t r;
        int               slot;
        int               i;
        logic [TIME_W-1:0] age;
        r           = '0;
        r.hb_status = ST_NONE;
        if (cmd == CMD_HEARTBEAT)
        begin
            // a zero id marks a free slot, so drop such a heartbeat untouched
            if (id != '0)
            begin
                slot = -1;
                for (i = 0; i < DEPTH; i++)
                    if (slot < 0 && peer_tab[i] == id)
                        slot = i;
                if (slot >= 0)
                begin
                    heard_at[slot] = now;
                    r.hb_status    = ST_REFRESHED;
                end
                else
                begin
                    for (i = 0; i < DEPTH; i++)
                        if (slot < 0 && peer_tab[i] == '0)
                            slot = i;
                    if (slot >= 0)
                    begin
                        peer_tab[slot] = id;
                        heard_at[slot] = now;
                        r.hb_status    = ST_INSERTED;
                    end
                    else
                        r.hb_status = ST_DROPPED;
                end
            end
        end
        else
        begin
            // expire first, then count what is left inside the window
            for (i = 0; i < DEPTH; i++)
            begin
                age = now - heard_at[i];
                if (peer_tab[i] != '0 && age > timeout_cfg)
                begin
                    peer_tab[i]     = '0;
                    heard_at[i]     = '0;
                    r.expired_count = r.expired_count + 1'b1;
                end
            end
            for (i = 0; i < DEPTH; i++)
            begin
                age = now - heard_at[i];
                if (peer_tab[i] != '0 && age <= window_cfg)
                    r.seen_count = r.seen_count + 1'b1;
            end
            r.group_present = (r.seen_count >= min_seen_cfg);
        end
        return r;
    endfunction

    // Compare each accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        presence_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result word with nothing expected", 32'(m_tdata), 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.hb_status)
                    report_mismatch("hb_status", 32'(m_tdata[1:0]), 32'(want.hb_status));
                if (m_tdata[8:2] !== want.seen_count)
                    report_mismatch("seen_count", 32'(m_tdata[8:2]), 32'(want.seen_count));
                if (m_tdata[9] !== want.group_present)
                    report_mismatch("group_present", 32'(m_tdata[9]),
                                    32'(want.group_present));
                if (m_tdata[16:10] !== want.expired_count)
                    report_mismatch("expired_count", 32'(m_tdata[16:10]),
                                    32'(want.expired_count));
                if (m_tdata[M_TDATA_W-1:OUT_USED_W] !== '0)
                    report_mismatch("pad bits", 32'(m_tdata[M_TDATA_W-1:OUT_USED_W]), 32'd0);
            end
        end
    end

    // Send one input word; return at the edge that accepts it with tvalid still high,
    // so a back-to-back word can follow without lowering it.
    task automatic send_presence_word(input logic cmd, input logic [PEER_W-1:0] id,
                                      input logic [TIME_W-1:0] now);
        while ($urandom_range(99, 0) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, id};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_presence(cmd, id, now));
    endtask

    task automatic send_heartbeat(input logic [PEER_W-1:0] id, input logic [TIME_W-1:0] now);
        send_presence_word(CMD_HEARTBEAT, id, now);
    endtask

    task automatic send_tick(input logic [TIME_W-1:0] now);
        // peer_id is unused on a tick; fill it with noise
        send_presence_word(CMD_TICK, PEER_W'($urandom_range(255, 0)), now);
    endtask

    // Hold off the sender until every predicted word has arrived, then let the block settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; call only while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_EXPIRE_TIMEOUT: timeout_cfg  = data;
            CFG_GROUP_WINDOW:   window_cfg   = data;
            CFG_GROUP_MIN_SEEN: min_seen_cfg = data[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [TIME_W-1:0] timeout, input logic [TIME_W-1:0] window,
                                  input logic [COUNT_W-1:0] min_seen);
        wait_drained();
        write_reg(CFG_EXPIRE_TIMEOUT, timeout);
        write_reg(CFG_GROUP_WINDOW, window);
        write_reg(CFG_GROUP_MIN_SEEN, CFG_DATA_W'(min_seen));
    endtask

    // Status codes: ignored zero id, inserts at both id extremes, refresh, first tick.
    task automatic test_heartbeat_codes();
        send_heartbeat(8'd0, 32'd100);
        send_heartbeat(8'd255, 32'd100);
        send_heartbeat(8'd1, 32'd200);
        send_heartbeat(8'd255, 32'd300);
        send_tick(32'd1000);
    endtask

    // Fill every slot, drop one more, refresh inside a full table.
    task automatic test_table_full();
        int id;
        for (id = 2; id < DEPTH; id++)
            send_heartbeat(PEER_W'(id), 32'd2000);
        send_heartbeat(8'd200, 32'd2000);
        send_heartbeat(8'd1, 32'd2000);
    endtask

    // Window and timeout edges (age equal and one past), then wrap of the time base.
    task automatic test_aging_edges();
        send_tick(32'd12000);
        send_tick(32'd12001);
        send_tick(32'd15300);
        send_tick(32'd15301);
        send_tick(32'd5);
        send_heartbeat(8'd200, 32'hFFFF_FF00);
        send_tick(32'h0000_0100);
    endtask

    // Register extremes, a minimum above the table size, and a write to no register.
    task automatic test_register_extremes();
        write_all_regs(32'd0, 32'd0, 7'd0);
        send_heartbeat(8'd9, 32'h8000_0000);
        send_tick(32'h8000_0000);
        send_tick(32'h8000_0001);
        write_all_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd64);
        send_heartbeat(8'd10, 32'd0);
        send_heartbeat(8'd11, 32'd7);
        send_tick(32'hFFFF_FFFF);
        write_all_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'(DEPTH + 1));
        write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
        send_tick(32'h1234_5678);
    endtask

    // Random traffic: mostly a small id pool on a steadily advancing clock, so entries
    // age through the window and the timeout; the rest is ticks, zero ids, wild ids and jumps.
    task automatic run_random_phase(input int n_items, input int step_max);
        int                k;
        int                pick;
        logic [TIME_W-1:0] cur_now;
        cur_now = $urandom();
        for (k = 0; k < n_items; k++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 5)
                cur_now = $urandom();
            else
                cur_now = cur_now + $urandom_range(step_max, 0);
            if (pick < 70)
                send_heartbeat(PEER_W'($urandom_range(18, 1)), cur_now);
            else if (pick < 92)
                send_tick(cur_now);
            else if (pick < 96)
                send_heartbeat(8'd0, $urandom());
            else
                send_heartbeat(PEER_W'($urandom_range(255, 0)), $urandom());
            // drain completely now and then
            if (k % 150 == 149)
                wait_drained();
        end
    endtask

    task automatic test_random_traffic();
        logic [TIME_W-1:0] timeout;
        logic [TIME_W-1:0] window;

        // sender idles a little, receiver a lot
        tx_idle_pct = 24;
        rx_idle_pct = 78;
        timeout = $urandom_range(20000, 3000);
        window  = $urandom_range(timeout, 500);
        write_all_regs(timeout, window, 7'($urandom_range(6, 0)));
        run_random_phase(300, timeout / 4 + 50);

        // the other way round
        tx_idle_pct = 78;
        rx_idle_pct = 24;
        timeout = $urandom_range(60000, 20000);
        window  = $urandom_range(70000, 0);
        write_all_regs(timeout, window,
                       ($urandom_range(3, 0) == 0) ? 7'd64 : 7'($urandom_range(8, 1)));
        run_random_phase(300, timeout / 4 + 50);

        // no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        timeout = $urandom_range(8000, 1000);
        window  = $urandom_range(12000, 0);
        write_all_regs(timeout, window, 7'($urandom_range(DEPTH, 0)));
        run_random_phase(300, timeout / 4 + 50);
    endtask

    initial
    begin
        int i;
        for (i = 0; i < DEPTH; i++)
        begin
            peer_tab[i] = '0;
            heard_at[i] = '0;
        end
        tx_idle_pct = 24;
        rx_idle_pct = 78;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_heartbeat_codes();
        test_table_full();
        test_aging_edges();
        test_register_extremes();
        test_random_traffic();

        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- peer_presence_aging_table.f -----
design/ppat_pkg.sv
design/ppat_ctrl.sv
design/ppat_datapath.sv
design/peer_presence_aging_table.sv
bench/tb.sv
